/* rtl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants, types and the rotate function for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int BlockBytes   = 64;
   localparam int LengthOffset = 56;
   localparam logic [7:0] PadMark = 8'h80;

   // initial hash values
   localparam logic [31:0] InitHash [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

   // round constants
   localparam logic [31:0] RoundConst [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B,
      32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01,
      32'h243185BE, 32'h550C7DC3, 32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7,
      32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA, 32'h983E5152,
      32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
      32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC,
      32'h53380D13, 32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3, 32'hD192E819,
      32'hD6990624, 32'hF40E3585, 32'h106AA070, 32'h19A4C116, 32'h1E376C08,
      32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F,
      32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

   // byte source for a buffer write
   localparam logic [1:0] SRC_DATA = 2'd0;
   localparam logic [1:0] SRC_PAD  = 2'd1;
   localparam logic [1:0] SRC_ZERO = 2'd2;
   localparam logic [1:0] SRC_LEN  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic       wr_en;       // write one byte into the block buffer
      logic [1:0] wr_src;      // which byte to write
      logic [2:0] len_sel;     // length byte index, 0 is most significant
      logic       len_inc;     // count one message byte
      logic       comp_start;  // start compressing the buffer
      logic       clear;       // back to initial state after digest
      logic       out_load;    // load digest word into output register
      logic [2:0] out_sel;     // which digest word
   } sha_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [5:0] fill;        // bytes held in the buffer
      logic       comp_busy;   // compression in progress
   } sha_stat_type;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int r);
      ror32 = (x >> r) | (x << (32 - r));
   endfunction

endpackage

/* rtl/sha_ctrl.sv */
// ----------------------------------------------------------------------------
// sha_ctrl
// Controller: accepts items, sequences padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_byte_present,
   input  logic                  req_message_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_word_number,
   output logic                  rsp_digest_done,
   output sha_pkg::sha_cmd_type  cmd,
   input  sha_pkg::sha_stat_type stat
);
   import sha_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;  // taking bytes
   localparam logic [2:0] ST_WAIT = 3'd1;  // block full, compressing
   localparam logic [2:0] ST_PAD  = 3'd2;  // padding after message end
   localparam logic [2:0] ST_FIN  = 3'd3;  // last compression running
   localparam logic [2:0] ST_OUT  = 3'd4;  // emitting digest words

   logic [2:0] state_ff, state_in;
   logic       pend_end_ff, pend_end_in;  // end seen with a byte that filled block
   logic       len_done_ff, len_done_in;  // pad mark written
   logic       tail_ff, tail_in;          // length bytes go into this block
   logic [3:0] word_ff, word_in;          // next digest word, 8 = all loaded
   logic       rv_ff, rv_in;
   logic [2:0] wn_ff, wn_in;
   logic       acc, out_take;

   assign req_ready       = (state_ff == ST_IDLE) && !stat.comp_busy;
   assign acc             = req_valid && req_ready;
   assign rsp_valid       = rv_ff;
   assign rsp_word_number = wn_ff;
   assign rsp_digest_done = (wn_ff == 3'd7);
   assign out_take        = !rv_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      pend_end_in = pend_end_ff;
      len_done_in = len_done_ff;
      tail_in     = tail_ff;
      word_in     = word_ff;
      rv_in       = rv_ff && !rsp_ready;
      wn_in       = wn_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_byte_present) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_src  = SRC_DATA;
                  cmd.len_inc = 1'b1;
                  if (stat.fill == 6'd63) begin
                     cmd.comp_start = 1'b1;
                     pend_end_in    = req_message_end;
                     state_in       = ST_WAIT;
                  end else if (req_message_end) begin
                     state_in = ST_PAD;
                  end
               end else if (req_message_end) begin
                  state_in = ST_PAD;
               end
               len_done_in = 1'b0;
            end
         end
         ST_WAIT: begin
            if (!stat.comp_busy) begin
               state_in = pend_end_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            // mark first, then zeros, length in the last 8 bytes of the final block
            if (!stat.comp_busy) begin
               cmd.wr_en = 1'b1;
               if (!len_done_ff) begin
                  cmd.wr_src = SRC_PAD;
                  tail_in    = (stat.fill < 6'(LengthOffset));
               end else if (tail_ff && stat.fill >= 6'(LengthOffset)) begin
                  cmd.wr_src  = SRC_LEN;
                  cmd.len_sel = 3'(stat.fill - 6'(LengthOffset));
               end else begin
                  cmd.wr_src = SRC_ZERO;
               end
               pend_end_in = 1'b0;
               len_done_in = 1'b1;
               if (stat.fill == 6'd63) begin
                  cmd.comp_start = 1'b1;
                  if (len_done_ff && tail_ff) begin
                     state_in = ST_FIN;
                  end else begin
                     tail_in = 1'b1;
                  end
               end
            end
         end
         ST_FIN: begin
            if (!stat.comp_busy) begin
               word_in  = 4'd0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (word_ff[3]) begin
               if (!rv_ff) begin
                  cmd.clear   = 1'b1;
                  len_done_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end else if (out_take) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = word_ff[2:0];
               rv_in        = 1'b1;
               wn_in        = word_ff[2:0];
               word_in      = word_ff + 4'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pend_end_ff <= 1'b0;
         len_done_ff <= 1'b0;
         tail_ff     <= 1'b0;
         word_ff     <= '0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_end_ff <= pend_end_in;
         len_done_ff <= len_done_in;
         tail_ff     <= tail_in;
         word_ff     <= word_in;
         rv_ff       <= rv_in;
      end
      wn_ff <= wn_in;
   end
endmodule

/* rtl/sha_dpath.sv */
// ----------------------------------------------------------------------------
// sha_dpath
// Datapath: block shift register, length counter, message schedule and round unit.
// ----------------------------------------------------------------------------
module sha_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_data_byte,
   input  sha_pkg::sha_cmd_type  cmd,
   output sha_pkg::sha_stat_type stat,
   output logic [31:0]           rsp_digest_word
);
   import sha_pkg::*;

   logic [503:0] blk_ff;            // last 63 bytes written, newest in the low byte
   logic [511:0] blk_full;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] chain_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];          // sliding schedule window
   logic [6:0]  rnd_ff, rnd_in;     // 0..63 rounds, 64 = final add
   logic        busy_ff, busy_in;
   logic [31:0] dout_ff;
   logic [63:0] bits;
   logic [7:0]  wr_byte;
   logic [31:0] s0, s1, w_new, big1, ch, t1, big0, mj;

   assign bits = {len_ff[60:0], 3'b000};
   assign blk_full = {blk_ff, wr_byte};
   assign stat.fill      = fill_ff;
   assign stat.comp_busy = busy_ff;
   assign rsp_digest_word = dout_ff;

   // byte to write
   always_comb begin
      case (cmd.wr_src)
         SRC_DATA: wr_byte = req_data_byte;
         SRC_PAD:  wr_byte = PadMark;
         SRC_ZERO: wr_byte = 8'h00;
         SRC_LEN:  wr_byte = bits[8'(7 - cmd.len_sel) * 8 +: 8];
         default:  wr_byte = 8'h00;
      endcase
   end

   // round logic
   assign s0    = ror32(w_ff[1], 7) ^ ror32(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1    = ror32(w_ff[14], 17) ^ ror32(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign w_new = w_ff[0] + s0 + w_ff[9] + s1;
   assign big1  = ror32(v_ff[4], 6) ^ ror32(v_ff[4], 11) ^ ror32(v_ff[4], 25);
   assign ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign t1    = v_ff[7] + big1 + ch + RoundConst[rnd_ff[5:0]] + w_ff[0];
   assign big0  = ror32(v_ff[0], 2) ^ ror32(v_ff[0], 13) ^ ror32(v_ff[0], 22);
   assign mj    = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);

   always_comb begin
      fill_in = cmd.wr_en ? fill_ff + 6'd1 : fill_ff;
      len_in  = cmd.len_inc ? len_ff + 64'd1 : len_ff;
      busy_in = busy_ff;
      rnd_in  = rnd_ff;
      if (cmd.comp_start) begin
         busy_in = 1'b1;
         rnd_in  = '0;
      end else if (busy_ff) begin
         rnd_in = rnd_ff + 7'd1;
         if (rnd_ff == 7'd64) busy_in = 1'b0;
      end
      if (cmd.clear) begin
         fill_in = '0;
         len_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         len_ff  <= '0;
         busy_ff <= 1'b0;
         rnd_ff  <= '0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= InitHash[i];
      end else begin
         fill_ff <= fill_in;
         len_ff  <= len_in;
         busy_ff <= busy_in;
         rnd_ff  <= rnd_in;
         if (cmd.clear) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= InitHash[i];
         end else if (busy_ff && rnd_ff == 7'd64) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + v_ff[i];
         end
      end
      // bytes shift in; 64 writes make one block
      if (cmd.wr_en) blk_ff <= blk_full[503:0];
      // load working variables and schedule window at start
      if (cmd.comp_start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= chain_ff[i];
         // last byte is being written this same cycle
         for (int i = 0; i < 16; i++) w_ff[i] <= blk_full[511 - 32*i -: 32];
      end else if (busy_ff && rnd_ff != 7'd64) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + big0 + mj;
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
      if (cmd.out_load) dout_ff <= chain_ff[cmd.out_sel];
   end
endmodule

/* rtl/sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, one optional byte per input item.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one item carries an optional byte (req_byte_present) and a
//   message end flag. Items are taken at one per cycle while a block fills.
//   When the 64th byte of a block arrives, the round unit runs 64 rounds
//   plus the chaining add, and req_ready stays low until it is done, so a
//   long message stalls its input once per 64 bytes.
//   At message end the controller writes padding one byte per cycle, while
//   no block is compressing, up to the end of the block, plus a whole second
//   padded block when fewer than 9 bytes remain, compressing each full
//   block as above. Word 0 is valid once the final compression is done;
//   the eight rsp_ items follow one per cycle while the receiver is ready,
//   word 0 first, and rsp_digest_done marks word 7.
//   A stalled receiver simply holds the output register; the block waits
//   and returns to the initial hash values after the last word is taken.
//   Reset (synchronous, active high) restores the initial hash values and
//   clears the fill and length counters.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_number,
   output logic        rsp_digest_done
);
   import sha_pkg::*;

   sha_cmd_type  cmd;
   sha_stat_type stat;

   sha_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_byte_present,
      .req_message_end, .rsp_valid, .rsp_ready, .rsp_word_number,
      .rsp_digest_done, .cmd, .stat
   );

   sha_dpath u_dpath (
      .clock, .reset, .req_data_byte, .cmd, .stat, .rsp_digest_word
   );
endmodule
